>>> hdl/mtf_pkg.sv
// Shared widths, record types, state codes and helpers of the multitaper F-test core.
package mtf_pkg;

  localparam int MAX_TAPERS = 6;
  localparam int MAX_BINS   = 65536;
  localparam int COEF_WIDTH = 24;

  localparam int WEIGHT_W   = 18;
  localparam int TAPER_W    = 3;
  localparam int BIN_W      = 16;
  localparam int BINCNT_W   = 17;
  localparam int PROD_W     = COEF_WIDTH + WEIGHT_W;
  localparam int SQ_W       = 2 * COEF_WIDTH;
  localparam int PROJ_W     = 45;
  localparam int ENERGY_W   = 52;
  localparam int OP_W       = 52;
  localparam int CHUNK_W    = OP_W / 2;
  localparam int ACC_W      = 88;
  localparam int S_W        = 37;
  localparam int KM1_W      = 3;
  localparam int PK_W       = ACC_W + KM1_W;
  localparam int FRAC_W     = 16;
  localparam int F_W        = 32;
  localparam int NUM_W      = PK_W + FRAC_W;
  localparam int REM_W      = ACC_W + 1;

  localparam int Q_DEPTH_DEF     = 2;
  localparam int CFG_IDX_W       = 4;
  localparam int CFG_DATA_W      = 18;
  localparam int TAPER_COUNT_RST = 5;
  localparam int BIN_COUNT_RST   = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_TAPER_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_0    = CFG_IDX_W'(2);

  typedef logic [MAX_TAPERS-1:0][WEIGHT_W-1:0] weight_bank_t;

  // one finished bin handed from the front to the back
  typedef struct packed {
    logic signed [PROJ_W-1:0] proj_real;
    logic signed [PROJ_W-1:0] proj_imag;
    logic [ENERGY_W-1:0]      energy;
    logic [TAPER_W-1:0]       taper_count;
    logic [BIN_W-1:0]         bin;
  } bin_rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUMW,
    ST_MUL,
    ST_DRAIN,
    ST_PREP,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } back_state_t;

  typedef enum logic [1:0] {
    DST_NONE,
    DST_S,
    DST_P2,
    DST_SE
  } acc_dst_t;

  function automatic logic [TAPER_W-1:0] clamp_taper_count(input logic [TAPER_W-1:0] k);
    logic [TAPER_W-1:0] r;
    if (k < TAPER_W'(2)) r = TAPER_W'(2);
    else if (k > TAPER_W'(MAX_TAPERS)) r = TAPER_W'(MAX_TAPERS);
    else r = k;
    return r;
  endfunction

  function automatic logic signed [WEIGHT_W-1:0] weight_at(input weight_bank_t bank,
                                                          input logic [TAPER_W-1:0] idx);
    logic signed [WEIGHT_W-1:0] r;
    if (idx >= TAPER_W'(MAX_TAPERS)) r = $signed(bank[MAX_TAPERS-1]);
    else r = $signed(bank[idx]);
    return r;
  endfunction

endpackage

>>> hdl/mtf_front.sv
// Front end: takes coefficient beats, tracks taper and bin, accumulates one bin.
module mtf_front #(
  parameter int QUEUE_DEPTH = 2,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [2*mtf_pkg::COEF_WIDTH-1:0]   in_tdata,
  input  logic [mtf_pkg::TAPER_W-1:0]        taper_count,
  input  logic [mtf_pkg::BINCNT_W-1:0]       bin_count,
  input  mtf_pkg::weight_bank_t              weights,
  input  logic [CNT_W-1:0]                   q_count,
  output logic                               push,
  output mtf_pkg::bin_rec_t                  push_rec
);
  import mtf_pkg::*;

  logic                         accept;
  logic signed [COEF_WIDTH-1:0] yr, yi;
  logic signed [WEIGHT_W-1:0]   w;
  logic [TAPER_W-1:0]           k_eff;
  logic                         last;
  logic [BINCNT_W-1:0]          bc_eff;
  logic                         bin_wrap;

  logic [TAPER_W-1:0] tc_r, tc_nxt;
  logic [BIN_W-1:0]   bin_r, bin_nxt;

  logic                     a_vld_r, a_last_r;
  logic signed [PROD_W-1:0] a_prod_re_r, a_prod_im_r;
  logic signed [SQ_W-1:0]   a_sq_re_r, a_sq_im_r;
  logic [TAPER_W-1:0]       a_k_r;
  logic [BIN_W-1:0]         a_bin_r;

  logic signed [PROJ_W-1:0] acc_re_r, acc_im_r, sum_re, sum_im;
  logic [ENERGY_W-1:0]      energy_r, sum_e;

  // room is counted with a last beat still in flight
  assign in_tready = ((CNT_W+1)'(q_count) + (CNT_W+1)'(a_vld_r & a_last_r))
                     < (CNT_W+1)'(QUEUE_DEPTH);
  assign accept = in_tvalid & in_tready;

  assign yr = $signed(in_tdata[COEF_WIDTH-1:0]);
  assign yi = $signed(in_tdata[2*COEF_WIDTH-1:COEF_WIDTH]);
  assign w  = weight_at(weights, tc_r);

  assign k_eff  = clamp_taper_count(taper_count);
  assign last   = ({1'b0, tc_r} + (TAPER_W+1)'(1)) >= {1'b0, k_eff};
  assign bc_eff = (bin_count == '0 || bin_count > BINCNT_W'(MAX_BINS)) ?
                  BINCNT_W'(MAX_BINS) : bin_count;
  assign bin_wrap = ({1'b0, bin_r} + BINCNT_W'(1)) >= bc_eff;

  always_comb begin
    tc_nxt  = tc_r;
    bin_nxt = bin_r;
    if (accept) begin
      if (last) begin
        tc_nxt  = '0;
        bin_nxt = bin_wrap ? '0 : bin_r + BIN_W'(1);
      end else begin
        tc_nxt = tc_r + TAPER_W'(1);
      end
    end
  end

  assign sum_re = acc_re_r + PROJ_W'(a_prod_re_r);
  assign sum_im = acc_im_r + PROJ_W'(a_prod_im_r);
  assign sum_e  = energy_r + ENERGY_W'(a_sq_re_r) + ENERGY_W'(a_sq_im_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r     <= '0;
      bin_r    <= '0;
      a_vld_r  <= 1'b0;
      a_last_r <= 1'b0;
      acc_re_r <= '0;
      acc_im_r <= '0;
      energy_r <= '0;
    end else begin
      tc_r     <= tc_nxt;
      bin_r    <= bin_nxt;
      a_vld_r  <= accept;
      a_last_r <= accept & last;
      if (a_vld_r) begin
        if (a_last_r) begin
          acc_re_r <= '0;
          acc_im_r <= '0;
          energy_r <= '0;
        end else begin
          acc_re_r <= sum_re;
          acc_im_r <= sum_im;
          energy_r <= sum_e;
        end
      end
    end
  end

  // product stage: one multiplier per term, registered before the sums
  always_ff @(posedge clk) begin
    if (accept) begin
      a_prod_re_r <= yr * w;
      a_prod_im_r <= yi * w;
      a_sq_re_r   <= yr * yr;
      a_sq_im_r   <= yi * yi;
      a_k_r       <= k_eff;
      a_bin_r     <= bin_r;
    end
  end

  assign push                 = a_vld_r & a_last_r;
  assign push_rec.proj_real   = sum_re;
  assign push_rec.proj_imag   = sum_im;
  assign push_rec.energy      = sum_e;
  assign push_rec.taper_count = a_k_r;
  assign push_rec.bin         = a_bin_r;

endmodule

>>> hdl/mtf_fifo.sv
// Short queue of finished bin records between the front and the back.
module mtf_fifo #(
  parameter int DEPTH = 2,
  localparam int CNT_W = $clog2(DEPTH + 1),
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mtf_pkg::bin_rec_t push_rec,
  output logic              pop_valid,
  input  logic              pop_ready,
  output mtf_pkg::bin_rec_t pop_rec,
  output logic [CNT_W-1:0]  count
);
  import mtf_pkg::*;

  bin_rec_t           mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               pop;

  assign pop_valid = count_r != '0;
  assign pop       = pop_valid & pop_ready;
  assign pop_rec   = mem_r[rd_ptr_r];
  assign count     = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + PTR_W'(1);
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + PTR_W'(1);
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_rec;
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> count_r < CNT_W'(DEPTH))
    else $error("record pushed into a full queue");

  a_count_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!push && !pop) |=> $stable(count_r))
    else $error("queue count moved without push or pop");

endmodule

>>> hdl/mtf_back.sv
// Back end: per-bin sequencer with a shared chunk multiplier and a radix-2 divider.
module mtf_back (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        q_valid,
  output logic                                        q_ready,
  input  mtf_pkg::bin_rec_t                           q_rec,
  input  mtf_pkg::weight_bank_t                       weights,
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  output logic [mtf_pkg::F_W+mtf_pkg::BIN_W-1:0]      out_tdata,
  output logic                                        out_tuser
);
  import mtf_pkg::*;

  localparam logic [3:0] LAST_STEP = 4'(3 * 4 - 1);

  back_state_t st_r, st_nxt;

  logic [TAPER_W-1:0] j_r, j_nxt;
  logic [3:0]         step_r, step_nxt;
  logic [4:0]         cnt_r, cnt_nxt;

  // bin operands
  logic [OP_W-1:0]    pr_mag_r, pi_mag_r, e_r;
  logic [TAPER_W-1:0] k_r;
  logic [BIN_W-1:0]   bin_r;

  // shared multiplier
  logic [CHUNK_W-1:0]   mul_a, mul_b;
  acc_dst_t             iss_dst, add_dst_r;
  logic [1:0]           iss_shift, add_shift_r;
  logic [2*CHUNK_W-1:0] prod_r;
  logic [ACC_W-1:0]     prod_sh;

  logic [S_W-1:0]   s_r;
  logic [ACC_W-1:0] p2_r, se_r, den_r;
  logic             flag_r;

  // division
  logic [REM_W-1:0] rem_r, den_ext, trial;
  logic [F_W-1:0]   low_r, q_r;
  logic             qbit, sat;
  logic [KM1_W-1:0] kx;
  logic [PK_W-1:0]  pk;
  logic [NUM_W-1:0] num;

  logic [OP_W-1:0]            opa, opb;
  logic signed [WEIGHT_W-1:0] wsel;
  logic [WEIGHT_W-1:0]        wabs;

  logic             load_out;
  logic             out_valid_r, out_flag_r;
  logic [F_W-1:0]   out_f_r;
  logic [BIN_W-1:0] out_bin_r;

  function automatic logic [OP_W-1:0] proj_mag(input logic signed [PROJ_W-1:0] v);
    logic [PROJ_W-1:0] u;
    u = v[PROJ_W-1] ? PROJ_W'(-v) : PROJ_W'(v);
    return OP_W'(u);
  endfunction

  assign wsel = weight_at(weights, j_r);
  assign wabs = wsel[WEIGHT_W-1] ? WEIGHT_W'(-wsel) : WEIGHT_W'(wsel);

  always_comb begin
    if (step_r[3:2] == 2'd0) begin
      opa = pr_mag_r;
      opb = pr_mag_r;
    end else if (step_r[3:2] == 2'd1) begin
      opa = pi_mag_r;
      opb = pi_mag_r;
    end else begin
      opa = e_r;
      opb = OP_W'(s_r);
    end
  end

  assign den_ext = REM_W'(den_r);
  assign sat     = flag_r | (rem_r >= den_ext);
  assign trial   = {rem_r[REM_W-2:0], low_r[F_W-1]};
  assign qbit    = trial >= den_ext;

  // |P|^2 * (K-1) by shift and add, K-1 at most five
  assign kx  = KM1_W'(k_r - TAPER_W'(1));
  assign pk  = (kx[0] ? PK_W'(p2_r) : '0) + (kx[1] ? PK_W'({p2_r, 1'b0}) : '0)
             + (kx[2] ? PK_W'({p2_r, 2'b00}) : '0);
  assign num = {pk, FRAC_W'(0)};

  always_comb begin
    st_nxt    = st_r;
    j_nxt     = j_r;
    step_nxt  = step_r;
    cnt_nxt   = cnt_r;
    q_ready   = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    iss_dst   = DST_NONE;
    iss_shift = 2'd0;
    load_out  = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          j_nxt  = '0;
          st_nxt = ST_SUMW;
        end
      end
      ST_SUMW: begin
        mul_a   = CHUNK_W'(wabs);
        mul_b   = CHUNK_W'(wabs);
        iss_dst = DST_S;
        j_nxt   = j_r + TAPER_W'(1);
        if (j_r == k_r - TAPER_W'(1)) begin
          step_nxt = '0;
          st_nxt   = ST_MUL;
        end
      end
      ST_MUL: begin
        mul_a     = step_r[1] ? opa[OP_W-1:CHUNK_W] : opa[CHUNK_W-1:0];
        mul_b     = step_r[0] ? opb[OP_W-1:CHUNK_W] : opb[CHUNK_W-1:0];
        iss_dst   = step_r[3] ? DST_SE : DST_P2;
        iss_shift = 2'(step_r[1]) + 2'(step_r[0]);
        step_nxt  = step_r + 4'd1;
        if (step_r == LAST_STEP) st_nxt = ST_DRAIN;
      end
      ST_DRAIN: st_nxt = ST_PREP;
      ST_PREP:  st_nxt = ST_CHECK;
      ST_CHECK: begin
        cnt_nxt = '0;
        st_nxt  = sat ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(F_W - 1)) st_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          load_out = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      j_r         <= '0;
      step_r      <= '0;
      cnt_r       <= '0;
      add_dst_r   <= DST_NONE;
      out_valid_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      j_r       <= j_nxt;
      step_r    <= step_nxt;
      cnt_r     <= cnt_nxt;
      add_dst_r <= iss_dst;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    unique case (add_shift_r)
      2'd1:    prod_sh = ACC_W'({prod_r, CHUNK_W'(0)});
      2'd2:    prod_sh = ACC_W'({prod_r, (2*CHUNK_W)'(0)});
      default: prod_sh = ACC_W'(prod_r);
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r      <= mul_a * mul_b;
    add_shift_r <= iss_shift;

    if (st_r == ST_IDLE && q_valid) begin
      pr_mag_r <= proj_mag(q_rec.proj_real);
      pi_mag_r <= proj_mag(q_rec.proj_imag);
      e_r      <= OP_W'(q_rec.energy);
      k_r      <= q_rec.taper_count;
      bin_r    <= q_rec.bin;
      s_r      <= '0;
      p2_r     <= '0;
      se_r     <= '0;
    end else begin
      unique case (add_dst_r)
        DST_S:   s_r  <= s_r + S_W'(prod_r);
        DST_P2:  p2_r <= p2_r + prod_sh;
        DST_SE:  se_r <= se_r + prod_sh;
        default: ;
      endcase
    end

    if (st_r == ST_PREP) begin
      flag_r <= p2_r >= se_r;
      den_r  <= se_r - p2_r;
      rem_r  <= REM_W'(num[NUM_W-1:F_W]);
      low_r  <= num[F_W-1:0];
    end

    if (st_r == ST_CHECK && sat) q_r <= '1;

    if (st_r == ST_DIV) begin
      rem_r <= qbit ? trial - den_ext : trial;
      low_r <= {low_r[F_W-2:0], 1'b0};
      q_r   <= {q_r[F_W-2:0], qbit};
    end

    if (load_out) begin
      out_f_r    <= q_r;
      out_bin_r  <= bin_r;
      out_flag_r <= flag_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_bin_r, out_f_r};
  assign out_tuser  = out_flag_r;

  a_flag_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_flag_r) |-> out_f_r == '1)
    else $error("residual flag without saturated F");

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DIV) |-> rem_r < den_ext)
    else $error("partial remainder not below divisor");

  a_div_not_flagged: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DIV) |-> !flag_r)
    else $error("division started on a non-positive denominator");

endmodule

>>> hdl/multitaper_f_test_core.sv
// Top level of the multitaper harmonic F-test core: configuration registers and wiring.
//
// Usage:
//   in_*  : one beat per taper eigencoefficient, tapers of one bin in order, taper 0 first.
//           The bin closes on the beat where the taper count reaches K (taper_count, 2..6).
//   out_* : one beat per closed bin carrying F (unsigned Q16.16, saturating) and the bin
//           index; out_tuser is high when S*E - |P|^2 is not positive (F then all ones).
//   cfg_* : register writes, taken every cycle; write only while no bin is open or pending.
// Timing:
//   The front takes one beat per cycle while in_tready is high and pushes a closed bin from
//   its registered product stage after the last beat. The back works one bin at a time:
//   weight squares, one per taper, 12 partial products of 26x26 on the shared multiplier,
//   the set-up states DRAIN, PREP and CHECK, then 32 quotient bits, one per cycle; when F
//   saturates the division is skipped. The back takes a new bin only after the last one
//   has left it, so over long runs the back, chiefly its divider, limits the input rate.
//   in_tready drops when the record queue (QUEUE_DEPTH bins) has no room left.
// Reset clears counters, the front accumulators and the queue, and loads taper_count 5,
// bin_count 1024 and zero weights. A stalled out_tready holds the result register; the
// back finishes the next bin and waits, and the queue then back-pressures the input.
module multitaper_f_test_core #(
  parameter int QUEUE_DEPTH = mtf_pkg::Q_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input beat
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [2*mtf_pkg::COEF_WIDTH-1:0]       in_tdata,  // coef_real, coef_imag
  // result beat
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [mtf_pkg::F_W+mtf_pkg::BIN_W-1:0] out_tdata, // f_value, bin_index
  output logic                                   out_tuser, // residual_zero
  // register writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [mtf_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [mtf_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import mtf_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [TAPER_W-1:0]  taper_count_r;
  logic [BINCNT_W-1:0] bin_count_r;
  weight_bank_t        weights_r;
  logic                cfg_wr;

  logic               push, q_valid, q_ready;
  bin_rec_t           push_rec, q_rec;
  logic [CNT_W-1:0]   q_count;

  // Accept every write; indexes past the last weight are dropped.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taper_count_r <= TAPER_W'(TAPER_COUNT_RST);
      bin_count_r   <= BINCNT_W'(BIN_COUNT_RST);
      weights_r     <= '0;
    end else if (cfg_wr) begin
      if (cfg_index == REG_TAPER_COUNT) taper_count_r <= cfg_data[TAPER_W-1:0];
      if (cfg_index == REG_BIN_COUNT)   bin_count_r   <= cfg_data[BINCNT_W-1:0];
      for (int j = 0; j < MAX_TAPERS; j++) begin
        if (cfg_index == REG_WEIGHT_0 + CFG_IDX_W'(j)) weights_r[j] <= cfg_data[WEIGHT_W-1:0];
      end
    end
  end

  // front: classify beats by taper, accumulate P and E, close bins
  mtf_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .taper_count (taper_count_r),
    .bin_count   (bin_count_r),
    .weights     (weights_r),
    .q_count     (q_count),
    .push        (push),
    .push_rec    (push_rec)
  );

  // queue: hold closed bins while the back is busy
  mtf_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (push_rec),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_rec   (q_rec),
    .count     (q_count)
  );

  // back: form S, |P|^2 and S*E, divide, drive the result register
  mtf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_rec      (q_rec),
    .weights    (weights_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
